FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file tmtw_checker
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define TMTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on the rising edge, off during reset
`define TMTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/tmtw_pkg.sv
// types, codes and constants of the text-mode terminal writer
// no dependencies; used by the top level, tmtw_ctrl, tmtw_dp and the checkers
package tmtw_pkg;

	localparam int CELL_W  = 16;
	localparam int APB_DW  = 32;
	localparam int PADDR_W = 4;

	typedef logic [7:0]         byte_t;
	typedef logic [1:0]         req_code_t;
	typedef logic [4:0]         row_f_t;
	typedef logic [6:0]         col_f_t;
	typedef logic [6:0]         plen_t;
	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [APB_DW-1:0]  apb_data_t;
	typedef logic [PADDR_W-1:0] apb_addr_t;
	typedef logic [1:0]         reg_idx_t;

	// request codes
	localparam req_code_t REQ_PUT   = 2'd0;
	localparam req_code_t REQ_CLEAR = 2'd1;
	localparam req_code_t REQ_GET   = 2'd2;
	localparam req_code_t REQ_READ  = 2'd3;

	// register indexes (byte address / 4)
	localparam reg_idx_t REG_TEXT_COLOR  = 2'd0;
	localparam reg_idx_t REG_PROMPT_CHAR = 2'd1;
	localparam reg_idx_t REG_PROMPT_DIST = 2'd2;

	localparam byte_t CH_NEWLINE   = 8'd10;
	localparam byte_t CH_BACKSPACE = 8'd8;
	localparam byte_t CH_SPACE     = 8'd32;

	localparam byte_t RESET_COLOR       = 8'd7;
	localparam byte_t RESET_PROMPT_CHAR = 8'd62;
	localparam plen_t RESET_PROMPT_DIST = 7'd3;

	typedef struct packed {
		req_code_t req_type;
		byte_t     char_code;
		row_f_t    read_row;
		col_f_t    read_col;
	} req_t;

	typedef struct packed {
		byte_t  cell_char;
		byte_t  cell_color;
		row_f_t cursor_row;
		col_f_t cursor_col;
	} rsp_t;

	typedef struct packed {
		byte_t text_color;
		byte_t prompt_char;
		plen_t prompt_dist;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_DATA,
		ST_PRIME,
		ST_SCROLL,
		ST_CLEAR,
		ST_RESP
	} ctl_state_t;

	typedef enum logic [2:0] {
		RD_BACK,
		RD_CURSOR,
		RD_PEEK,
		RD_SCROLL_FIRST,
		RD_SCROLL_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_CHAR,
		WR_BS_SPACE,
		WR_INIT,
		WR_CLEAR,
		WR_SCROLL
	} wr_sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ADVANCE,
		CUR_NEWLINE,
		CUR_BACK,
		CUR_HOME
	} cur_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		cur_op_t cur_op;
		logic    cap_cell;
		logic    sweep_inc;
		logic    sweep_clr;
		logic    finish;
	} ctl_cmd_t;

	typedef struct packed {
		req_code_t req_type;
		logic      is_newline;
		logic      is_backspace;
		logic      nl_scroll;
		logic      wrap_scroll;
		logic      bs_blocked;
		logic      sweep_last;
		logic      out_free;
	} dp_status_t;

endpackage

FILE: rtl/core/tmtw_stream_if.sv
// valid/ready stream channel with a typed payload
// payload type comes from tmtw_pkg at the instance
interface tmtw_stream_if #(parameter type payload_t = logic);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

FILE: rtl/core/text_mode_terminal_writer.sv
// top level of the text-mode terminal writer: apb registers, controller, datapath
// depends on tmtw_pkg, tmtw_stream_if, tmtw_ctrl, tmtw_dp
//
//  channel | direction | handshake             | beat payload
//  --------+-----------+-----------------------+-------------------------------------------
//  req     | in        | valid/ready           | req_type, char_code, read_row, read_col
//  rsp     | out       | valid/ready           | cell_char, cell_color, cursor_row, cursor_col
//  apb     | in        | psel/penable, pready  | text_color 0x0, prompt_char 0x4, prompt_dist 0x8
//
// one request is worked at a time; the one-read, one-write screen ram sets the steps:
// printable put or newline ends in exec; backspace, get and read end in the data state.
// a scroll adds a prime state and a sweep over every cell; clear is one such sweep.
// after reset a clearing pass over every cell fills the screen; req.ready is low.
// the result beat sits in an output register, so a new request is taken while it waits;
// a stalled rsp holds the block only when the next result is due.
module text_mode_terminal_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  tmtw_pkg::apb_addr_t       paddr,
	input  tmtw_pkg::apb_data_t       pwdata,
	output tmtw_pkg::apb_data_t       prdata,
	output logic                      pready,
	// streams
	tmtw_stream_if.sink               req,
	tmtw_stream_if.source             rsp
);

	tmtw_pkg::cfg_t       cfg_q;
	tmtw_pkg::ctl_cmd_t   cmd;
	tmtw_pkg::dp_status_t status;
	tmtw_pkg::reg_idx_t   reg_idx;
	logic                 cfg_wr;

	// register file, written in the apb access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color  <= tmtw_pkg::RESET_COLOR;
			cfg_q.prompt_char <= tmtw_pkg::RESET_PROMPT_CHAR;
			cfg_q.prompt_dist <= tmtw_pkg::RESET_PROMPT_DIST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tmtw_pkg::REG_TEXT_COLOR:  cfg_q.text_color  <= pwdata[7:0];
				tmtw_pkg::REG_PROMPT_CHAR: cfg_q.prompt_char <= pwdata[7:0];
				tmtw_pkg::REG_PROMPT_DIST: cfg_q.prompt_dist <= pwdata[6:0];
				default:                   cfg_q             <= cfg_q;
			endcase
		end
	end

	// read-back, unmapped addresses read zero
	always_comb begin
		case (reg_idx)
			tmtw_pkg::REG_TEXT_COLOR:  prdata = tmtw_pkg::apb_data_t'(cfg_q.text_color);
			tmtw_pkg::REG_PROMPT_CHAR: prdata = tmtw_pkg::apb_data_t'(cfg_q.prompt_char);
			tmtw_pkg::REG_PROMPT_DIST: prdata = tmtw_pkg::apb_data_t'(cfg_q.prompt_dist);
			default:                   prdata = '0;
		endcase
	end

	// sequencer: request decode, sweeps over the screen, result timing
	tmtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.status    (status),
		.cmd       (cmd)
	);

	// screen store, cursor and result register
	tmtw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.req_valid (req.valid),
		.req_data  (req.payload),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.payload),
		.status    (status)
	);

	assign req.ready = cmd.in_ready;

endmodule

FILE: rtl/core/tmtw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tmtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tmtw_ctrl.sv
// controller state machine of the terminal writer
// depends on tmtw_pkg; drives tmtw_dp through ctl_cmd_t
module tmtw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  tmtw_pkg::dp_status_t   status,
	output tmtw_pkg::ctl_cmd_t     cmd
);

	tmtw_pkg::ctl_state_t state_q;
	tmtw_pkg::ctl_state_t state_d;
	tmtw_pkg::ctl_state_t done_st;

	assign done_st = status.out_free ? tmtw_pkg::ST_IDLE : tmtw_pkg::ST_RESP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmtw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmtw_pkg::ST_INIT: begin
				if (status.sweep_last) state_d = tmtw_pkg::ST_IDLE;
			end
			tmtw_pkg::ST_IDLE: begin
				if (req_valid) state_d = tmtw_pkg::ST_EXEC;
			end
			tmtw_pkg::ST_EXEC: begin
				case (status.req_type)
					tmtw_pkg::REQ_PUT: begin
						if (status.is_newline) begin
							state_d = status.nl_scroll ? tmtw_pkg::ST_PRIME : done_st;
						end else if (status.is_backspace) begin
							state_d = tmtw_pkg::ST_DATA;
						end else begin
							state_d = status.wrap_scroll ? tmtw_pkg::ST_PRIME : done_st;
						end
					end
					tmtw_pkg::REQ_CLEAR: state_d = tmtw_pkg::ST_CLEAR;
					tmtw_pkg::REQ_GET:   state_d = tmtw_pkg::ST_DATA;
					tmtw_pkg::REQ_READ:  state_d = tmtw_pkg::ST_DATA;
					default:             state_d = tmtw_pkg::ST_IDLE;
				endcase
			end
			tmtw_pkg::ST_DATA: begin
				if (status.req_type == tmtw_pkg::REQ_GET && status.wrap_scroll) begin
					state_d = tmtw_pkg::ST_PRIME;
				end else begin
					state_d = done_st;
				end
			end
			tmtw_pkg::ST_PRIME: state_d = tmtw_pkg::ST_SCROLL;
			tmtw_pkg::ST_SCROLL: begin
				if (status.sweep_last) state_d = done_st;
			end
			tmtw_pkg::ST_CLEAR: begin
				if (status.sweep_last) state_d = done_st;
			end
			tmtw_pkg::ST_RESP: begin
				if (status.out_free) state_d = tmtw_pkg::ST_IDLE;
			end
			default: state_d = tmtw_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = tmtw_pkg::RD_CURSOR;
		cmd.wr_sel = tmtw_pkg::WR_CHAR;
		cmd.cur_op = tmtw_pkg::CUR_HOLD;
		case (state_q)
			tmtw_pkg::ST_INIT: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = tmtw_pkg::WR_INIT;
				cmd.sweep_inc = 1'b1;
				cmd.sweep_clr = status.sweep_last;
			end
			tmtw_pkg::ST_IDLE: cmd.in_ready = 1'b1;
			tmtw_pkg::ST_EXEC: begin
				case (status.req_type)
					tmtw_pkg::REQ_PUT: begin
						if (status.is_newline) begin
							cmd.cur_op = tmtw_pkg::CUR_NEWLINE;
							cmd.finish = !status.nl_scroll && status.out_free;
						end else if (status.is_backspace) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = tmtw_pkg::RD_BACK;
						end else begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = tmtw_pkg::WR_CHAR;
							cmd.cur_op = tmtw_pkg::CUR_ADVANCE;
							cmd.finish = !status.wrap_scroll && status.out_free;
						end
					end
					tmtw_pkg::REQ_GET: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = tmtw_pkg::RD_CURSOR;
					end
					tmtw_pkg::REQ_READ: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = tmtw_pkg::RD_PEEK;
					end
					default: cmd.in_ready = 1'b0;
				endcase
			end
			tmtw_pkg::ST_DATA: begin
				case (status.req_type)
					tmtw_pkg::REQ_PUT: begin
						if (!status.bs_blocked) begin
							cmd.cur_op = tmtw_pkg::CUR_BACK;
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = tmtw_pkg::WR_BS_SPACE;
						end
						cmd.finish = status.out_free;
					end
					tmtw_pkg::REQ_GET: begin
						cmd.cap_cell = 1'b1;
						cmd.cur_op   = tmtw_pkg::CUR_ADVANCE;
						cmd.finish   = !status.wrap_scroll && status.out_free;
					end
					default: begin
						cmd.cap_cell = 1'b1;
						cmd.finish   = status.out_free;
					end
				endcase
			end
			tmtw_pkg::ST_PRIME: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = tmtw_pkg::RD_SCROLL_FIRST;
			end
			tmtw_pkg::ST_SCROLL: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = tmtw_pkg::WR_SCROLL;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = tmtw_pkg::RD_SCROLL_NEXT;
				cmd.sweep_inc = 1'b1;
				cmd.sweep_clr = status.sweep_last;
				cmd.finish    = status.sweep_last && status.out_free;
			end
			tmtw_pkg::ST_CLEAR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = tmtw_pkg::WR_CLEAR;
				cmd.sweep_inc = 1'b1;
				cmd.sweep_clr = status.sweep_last;
				if (status.sweep_last) begin
					cmd.cur_op = tmtw_pkg::CUR_HOME;
					cmd.finish = status.out_free;
				end
			end
			tmtw_pkg::ST_RESP: cmd.finish = status.out_free;
			default: cmd.in_ready = 1'b0;
		endcase
	end

endmodule

FILE: rtl/core/tmtw_dp.sv
// datapath: screen ram, cursor, request and result registers, sweep counter
// depends on tmtw_pkg and tmtw_ram; steered by tmtw_ctrl
module tmtw_dp #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmtw_pkg::ctl_cmd_t   cmd,
	input  tmtw_pkg::cfg_t       cfg,
	input  logic                 req_valid,
	input  tmtw_pkg::req_t       req_data,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output tmtw_pkg::rsp_t       rsp_data,
	output tmtw_pkg::dp_status_t status
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
	localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
	localparam logic [AW-1:0] SCROLL_SPAN = AW'(CELLS - COLUMNS);

	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [AW-1:0]     sweep_q;
	tmtw_pkg::req_t    req_q;
	tmtw_pkg::cell_t   cell_q, cell_d;
	logic              out_valid_q;
	tmtw_pkg::rsp_t    out_q;

	logic [AW-1:0]     cur_idx, back_idx, bs_idx, peek_idx;
	logic              bs_reach, peek_ok, shows_cell;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	tmtw_pkg::cell_t   ram_wdata, ram_rdata;
	tmtw_pkg::cell_t   space_cell;

	assign space_cell = {cfg.text_color, tmtw_pkg::CH_SPACE};

	// linear cell positions
	assign cur_idx  = AW'(row_q) * ROW_STRIDE + AW'(col_q);
	assign bs_reach = int'(cur_idx) >= int'(cfg.prompt_dist);
	assign back_idx = cur_idx - AW'(cfg.prompt_dist);
	assign bs_idx   = (cur_idx == '0) ? '0 : cur_idx - AW'(1);
	assign peek_ok  = (int'(req_q.read_row) < ROWS) && (int'(req_q.read_col) < COLUMNS);
	assign peek_idx = AW'(req_q.read_row) * ROW_STRIDE + AW'(req_q.read_col);

	// read port
	assign ram_re = cmd.rd_en;
	always_comb begin
		case (cmd.rd_sel)
			tmtw_pkg::RD_BACK:         ram_raddr = back_idx;
			tmtw_pkg::RD_CURSOR:       ram_raddr = cur_idx;
			tmtw_pkg::RD_PEEK:         ram_raddr = peek_idx;
			tmtw_pkg::RD_SCROLL_FIRST: ram_raddr = sweep_q + ROW_STRIDE;
			tmtw_pkg::RD_SCROLL_NEXT:  ram_raddr = sweep_q + ROW_STRIDE + AW'(1);
			default:                   ram_raddr = cur_idx;
		endcase
	end

	// write port
	assign ram_we = cmd.wr_en;
	always_comb begin
		case (cmd.wr_sel)
			tmtw_pkg::WR_CHAR: begin
				ram_waddr = cur_idx;
				ram_wdata = {cfg.text_color, req_q.char_code};
			end
			tmtw_pkg::WR_BS_SPACE: begin
				ram_waddr = bs_idx;
				ram_wdata = space_cell;
			end
			tmtw_pkg::WR_INIT: begin
				ram_waddr = sweep_q;
				ram_wdata = {tmtw_pkg::RESET_COLOR, tmtw_pkg::CH_SPACE};
			end
			tmtw_pkg::WR_CLEAR: begin
				ram_waddr = sweep_q;
				ram_wdata = space_cell;
			end
			tmtw_pkg::WR_SCROLL: begin
				// rows move up one; the last row becomes blank
				ram_waddr = sweep_q;
				ram_wdata = (sweep_q < SCROLL_SPAN) ? ram_rdata : space_cell;
			end
			default: begin
				ram_waddr = cur_idx;
				ram_wdata = space_cell;
			end
		endcase
	end

	tmtw_ram #(
		.WIDTH (tmtw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_screen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// cursor update
	always_comb begin
		row_d = row_q;
		col_d = col_q;
		case (cmd.cur_op)
			tmtw_pkg::CUR_ADVANCE: begin
				if (col_q == LAST_COL) begin
					col_d = '0;
					row_d = (row_q == LAST_ROW) ? row_q : row_q + RW'(1);
				end else begin
					col_d = col_q + CW'(1);
				end
			end
			tmtw_pkg::CUR_NEWLINE: begin
				col_d = '0;
				row_d = (row_q == LAST_ROW) ? row_q : row_q + RW'(1);
			end
			tmtw_pkg::CUR_BACK: begin
				if (col_q == '0) begin
					if (row_q != '0) begin
						row_d = row_q - RW'(1);
						col_d = LAST_COL;
					end
				end else begin
					col_d = col_q - CW'(1);
				end
			end
			tmtw_pkg::CUR_HOME: begin
				row_d = '0;
				col_d = '0;
			end
			default: begin
				row_d = row_q;
				col_d = col_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			row_q <= row_d;
			col_q <= col_d;
			if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_inc) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cell_d = cmd.cap_cell ?
		((req_q.req_type == tmtw_pkg::REQ_READ && !peek_ok) ? '0 : ram_rdata) : cell_q;
	assign shows_cell = (req_q.req_type == tmtw_pkg::REQ_GET) ||
		(req_q.req_type == tmtw_pkg::REQ_READ);

	always_ff @(posedge clk) begin
		if (req_valid && cmd.in_ready) begin
			req_q <= req_data;
		end
		cell_q <= cell_d;
		if (cmd.finish) begin
			out_q.cell_char  <= shows_cell ? cell_d[7:0] : '0;
			out_q.cell_color <= shows_cell ? cell_d[15:8] : '0;
			out_q.cursor_row <= tmtw_pkg::row_f_t'(row_d);
			out_q.cursor_col <= tmtw_pkg::col_f_t'(col_d);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	assign status.req_type     = req_q.req_type;
	assign status.is_newline   = req_q.char_code == tmtw_pkg::CH_NEWLINE;
	assign status.is_backspace = req_q.char_code == tmtw_pkg::CH_BACKSPACE;
	assign status.nl_scroll    = row_q == LAST_ROW;
	assign status.wrap_scroll  = (row_q == LAST_ROW) && (col_q == LAST_COL);
	assign status.bs_blocked   = bs_reach && (ram_rdata[7:0] == cfg.prompt_char);
	assign status.sweep_last   = sweep_q == LAST_CELL;
	assign status.out_free     = !out_valid_q || rsp_ready;

endmodule

FILE: rtl/core/tmtw_checker.sv
// port-level checks of the terminal writer, bound to the top level
// depends on tmtw_pkg and assert_macros.svh
`include "assert_macros.svh"

module tmtw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tmtw_pkg::rsp_t rsp_data
);

	// a stalled result beat stays and holds its payload
	`TMTW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// requests are worked one at a time: no second beat right after an accept
	`TMTW_ASSERT_NEXT(a_one_in_work, clk, arst_n, req_valid && req_ready, !req_ready)

	// the reported cursor is always on the screen
	`TMTW_ASSERT_NOW(a_cursor_on_screen, clk, arst_n, rsp_valid, (int'(rsp_data.cursor_row) < ROWS) && (int'(rsp_data.cursor_col) < COLUMNS))

endmodule

bind text_mode_terminal_writer tmtw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tmtw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.payload)
);

FILE: verif/tmtw_screen_checker.sv
`timescale 1ns / 1ps
// checker for the text-mode terminal writer: mirrors the screen, cursor and
// registers from the observed apb writes and request beats, and compares every result beat
// depends on tmtw_pkg
module tmtw_screen_checker
	import tmtw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      psel,
	input  logic      penable,
	input  logic      pwrite,
	input  apb_addr_t paddr,
	input  apb_data_t pwdata,
	input  logic      pready,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_t      req_beat,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_t      rsp_beat,
	output int        fail_count,
	output int        pending,
	output int        checked,
	output int        scrolls,
	output int        blocked_bs
);

	localparam int CELLS = ROWS * COLUMNS;

	cell_t       screen [CELLS];
	int unsigned cur_row;
	int unsigned cur_col;
	cfg_t        regs;
	rsp_t        due_results [$];
	int          n_fail;
	int          n_checked;
	int          n_scroll;
	int          n_blocked;

	function automatic cell_t colored(byte_t ch);
		return {regs.text_color, ch};
	endfunction

	function automatic void blank_all();
		for (int i = 0; i < CELLS; i++)
			screen[i] = colored(CH_SPACE);
	endfunction

	function automatic void line_feed();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = ROWS - 1;
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = colored(CH_SPACE);
			n_scroll++;
		end
	endfunction

	function automatic void step_cursor();
		cur_col++;
		if (cur_col >= COLUMNS)
			line_feed();
	endfunction

	function automatic void rub_out();
		int unsigned idx;
		idx = cur_row * COLUMNS + cur_col;
		// prompt character prompt_dist cells back holds the cursor; before cell 0 never matches
		if (idx >= regs.prompt_dist && screen[idx - regs.prompt_dist][7:0] == regs.prompt_char) begin
			n_blocked++;
			return;
		end
		if (cur_col == 0) begin
			if (cur_row != 0) begin
				cur_row--;
				cur_col = COLUMNS - 1;
			end
		end else begin
			cur_col--;
		end
		screen[cur_row * COLUMNS + cur_col] = colored(CH_SPACE);
	endfunction

	function automatic rsp_t term_apply(req_t r);
		rsp_t  o;
		cell_t c;
		o = '0;
		case (r.req_type)
			REQ_PUT: begin
				if (r.char_code == CH_NEWLINE)
					line_feed();
				else if (r.char_code == CH_BACKSPACE)
					rub_out();
				else begin
					screen[cur_row * COLUMNS + cur_col] = colored(r.char_code);
					step_cursor();
				end
			end
			REQ_CLEAR: begin
				blank_all();
				cur_row = 0;
				cur_col = 0;
			end
			REQ_GET: begin
				c = screen[cur_row * COLUMNS + cur_col];
				o.cell_char  = c[7:0];
				o.cell_color = c[15:8];
				step_cursor();
			end
			default: begin
				if (r.read_row < ROWS && r.read_col < COLUMNS) begin
					c = screen[r.read_row * COLUMNS + r.read_col];
					o.cell_char  = c[7:0];
					o.cell_color = c[15:8];
				end
			end
		endcase
		o.cursor_row = row_f_t'(cur_row);
		o.cursor_col = col_f_t'(cur_col);
		return o;
	endfunction

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			regs = {RESET_COLOR, RESET_PROMPT_CHAR, RESET_PROMPT_DIST};
			blank_all();
			cur_row = 0;
			cur_col = 0;
			due_results.delete();
			n_fail = 0;
			n_checked = 0;
			n_scroll = 0;
			n_blocked = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
			scrolls <= 0;
			blocked_bs <= 0;
		end else begin
			// result beats leave an output register, so they always belong to older requests
			if (rsp_valid && rsp_ready) begin
				n_checked++;
				if (due_results.size() == 0) begin
					note_fail($sformatf("unexpected result beat: char %02h color %02h cursor %0d,%0d",
						rsp_beat.cell_char, rsp_beat.cell_color,
						rsp_beat.cursor_row, rsp_beat.cursor_col));
				end else begin
					want = due_results.pop_front();
					if (want.cell_char !== rsp_beat.cell_char ||
					    want.cell_color !== rsp_beat.cell_color ||
					    want.cursor_row !== rsp_beat.cursor_row ||
					    want.cursor_col !== rsp_beat.cursor_col)
						note_fail($sformatf({"result mismatch: expected char %02h color %02h",
							" cursor %0d,%0d, got char %02h color %02h cursor %0d,%0d"},
							want.cell_char, want.cell_color, want.cursor_row, want.cursor_col,
							rsp_beat.cell_char, rsp_beat.cell_color,
							rsp_beat.cursor_row, rsp_beat.cursor_col));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_TEXT_COLOR:  regs.text_color = pwdata[7:0];
					REG_PROMPT_CHAR: regs.prompt_char = pwdata[7:0];
					REG_PROMPT_DIST: regs.prompt_dist = pwdata[6:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				due_results.push_back(term_apply(req_beat));
			fail_count <= n_fail;
			pending <= due_results.size();
			checked <= n_checked;
			scrolls <= n_scroll;
			blocked_bs <= n_blocked;
		end
	end

endmodule

FILE: verif/text_mode_terminal_writer_tb.sv
`timescale 1ns / 1ps
// top of the text-mode terminal writer testbench: clock, reset, apb settings and request stimulus
// depends on tmtw_pkg, tmtw_stream_if, text_mode_terminal_writer and tmtw_screen_checker
module text_mode_terminal_writer_tb;
	import tmtw_pkg::*;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int SEGMENTS  = 6;
	localparam int SEG_ITEMS = 117;
	// several times the slowest expected run, scrolls and clears included
	localparam int LIMIT_NS  = 100_000_000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      psel;
	logic      penable;
	logic      pwrite;
	apb_addr_t paddr;
	apb_data_t pwdata;
	apb_data_t prdata;
	logic      pready;

	tmtw_stream_if #(.payload_t(req_t)) req_ch ();
	tmtw_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	int fail_count;
	int pending;
	int checked;
	int scrolls;
	int blocked_bs;

	// idle odds in percent for the request sender and the result receiver
	int src_idle;
	int dst_idle;

	// what the stimulus side knows of the current prompt setting
	byte_t cur_sym;
	plen_t cur_len;

	int n_items;
	int n_put;
	int n_clear;
	int n_get;
	int n_read;
	int n_settings;
	int seg_start;

	text_mode_terminal_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tmtw_screen_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) i_screen_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_beat  (req_ch.payload),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_beat  (rsp_ch.payload),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked),
		.scrolls   (scrolls),
		.blocked_bs(blocked_bs)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#LIMIT_NS;
		$display("== FAIL ==");
		$finish;
	end

	// result receiver: ready drops at random, odds follow the current phase
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
		end
	end

	// request with random filler in the row and column fields
	function automatic req_t any_req(req_code_t t, byte_t ch);
		return {t, ch, row_f_t'($urandom_range(0, 31)), col_f_t'($urandom_range(0, 127))};
	endfunction

	// read cell request, the unused char field random
	function automatic req_t read_req(int rr, int rc);
		return {REQ_READ, byte_t'($urandom_range(0, 255)), row_f_t'(rr), col_f_t'(rc)};
	endfunction

	// any byte that prints as itself
	function automatic byte_t glyph();
		byte_t ch;
		do
			ch = byte_t'($urandom_range(0, 255));
		while (ch == CH_NEWLINE || ch == CH_BACKSPACE);
		return ch;
	endfunction

	// one request beat; valid stays high across back-to-back beats
	task automatic send_req(req_t r);
		if (src_idle != 0 && $urandom_range(0, 99) < src_idle) begin
			req_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		n_items++;
		case (r.req_type)
			REQ_PUT:   n_put++;
			REQ_CLEAR: n_clear++;
			REQ_GET:   n_get++;
			default:   n_read++;
		endcase
	endtask

	// hold requests back until the checker has seen every result
	task automatic wait_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// apb write: setup phase, access phase until pready, then back to idle
	task automatic apb_write(reg_idx_t idx, apb_data_t val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= apb_addr_t'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block idle
	task automatic load_settings(byte_t color, byte_t sym, plen_t len);
		wait_results();
		apb_write(REG_TEXT_COLOR, apb_data_t'(color));
		apb_write(REG_PROMPT_CHAR, apb_data_t'(sym));
		apb_write(REG_PROMPT_DIST, apb_data_t'(len));
		cur_sym = sym;
		cur_len = len;
		n_settings++;
	endtask

	// one random burst of requests, mostly shaped like terminal use
	task automatic random_sequence();
		int pick;
		int k;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			// run of text, may wrap and scroll at the bottom
			n = $urandom_range(1, 12);
			repeat (n) send_req(any_req(REQ_PUT, glyph()));
		end else if (pick < 43) begin
			// prompt, a few characters, then backspaces that run into the prompt
			if ($urandom_range(0, 1) != 0)
				send_req(any_req(REQ_PUT, CH_NEWLINE));
			send_req(any_req(REQ_PUT, cur_sym));
			k = (cur_len <= 10) ? $urandom_range(0, cur_len + 1) : $urandom_range(0, 4);
			repeat (k) send_req(any_req(REQ_PUT, glyph()));
			n = $urandom_range(1, k + 3);
			repeat (n) send_req(any_req(REQ_PUT, CH_BACKSPACE));
		end else if (pick < 51) begin
			n = $urandom_range(1, 3);
			repeat (n) send_req(any_req(REQ_PUT, CH_NEWLINE));
		end else if (pick < 53) begin
			// long newline run, may reach the bottom row and scroll
			n = $urandom_range(20, 26);
			repeat (n) send_req(any_req(REQ_PUT, CH_NEWLINE));
		end else if (pick < 63) begin
			n = $urandom_range(1, 4);
			repeat (n) send_req(any_req(REQ_GET, byte_t'($urandom_range(0, 255))));
		end else if (pick < 78) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(0, 3) != 0)
					send_req(read_req($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1)));
				else
					send_req(read_req($urandom_range(0, 31), $urandom_range(0, 127)));
			end
		end else if (pick < 81) begin
			send_req(any_req(REQ_CLEAR, byte_t'($urandom_range(0, 255))));
		end else if (pick < 91) begin
			// backspaces, crossing line starts
			n = $urandom_range(1, 5);
			repeat (n) send_req(any_req(REQ_PUT, CH_BACKSPACE));
		end else begin
			// noise: every field random
			send_req(any_req(req_code_t'($urandom_range(0, 3)), byte_t'($urandom_range(0, 255))));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;
		src_idle       = 33;
		dst_idle       = 67;
		cur_sym        = RESET_PROMPT_CHAR;
		cur_len        = RESET_PROMPT_DIST;
		n_items        = 0;
		n_put          = 0;
		n_clear        = 0;
		n_get          = 0;
		n_read         = 0;
		n_settings     = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings; the first beat waits out the clearing pass
		send_req(read_req(0, 0));
		send_req(read_req(ROWS - 1, COLUMNS - 1));
		send_req(read_req(ROWS, 0));                  // row out of range
		send_req(read_req(0, COLUMNS));               // column out of range
		send_req(read_req(31, 127));                  // both fields at their top
		send_req(any_req(REQ_PUT, CH_BACKSPACE));     // top left: cursor stays, space written
		send_req(any_req(REQ_PUT, 8'h00));
		send_req(any_req(REQ_PUT, 8'hFF));
		send_req(any_req(REQ_PUT, 8'h41));
		send_req(any_req(REQ_GET, 8'h00));
		send_req(any_req(REQ_PUT, RESET_PROMPT_CHAR));
		send_req(any_req(REQ_PUT, 8'h78));
		send_req(any_req(REQ_PUT, 8'h79));
		send_req(any_req(REQ_PUT, 8'h7A));
		send_req(any_req(REQ_PUT, CH_BACKSPACE));     // one step back
		send_req(any_req(REQ_PUT, CH_BACKSPACE));     // now held by the prompt symbol
		send_req(read_req(0, 7));
		send_req(any_req(REQ_PUT, CH_NEWLINE));
		send_req(any_req(REQ_PUT, CH_BACKSPACE));     // column zero: up to the last column
		send_req(any_req(REQ_PUT, 8'h51));            // last column: wraps to the next row
		send_req(read_req(0, COLUMNS - 1));
		send_req(any_req(REQ_CLEAR, 8'hFF));
		send_req(any_req(REQ_GET, 8'hFF));

		// random part: two segments per idle phase, new settings for each segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: load_settings(8'h00, 8'h00, 7'd0);
				1: load_settings(8'hFF, 8'hFF, 7'd79);
				2: load_settings(byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(33, 126)), plen_t'($urandom_range(1, 8)));
				3: load_settings(byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(0, 255)), plen_t'($urandom_range(0, 79)));
				4: load_settings(8'h70, RESET_PROMPT_CHAR, 7'd1);
				default: load_settings(byte_t'($urandom_range(0, 255)),
					byte_t'($urandom_range(0, 255)), plen_t'($urandom_range(0, 79)));
			endcase
			if (seg == 2) begin
				src_idle = 67;
				dst_idle <= 33;
			end else if (seg == 4) begin
				src_idle = 0;
				dst_idle <= 0;
			end
			seg_start = n_items;
			while (n_items - seg_start < SEG_ITEMS)
				random_sequence();
		end

		// drain, then watch a full scroll time for stray beats
		wait_results();
		repeat (ROWS * COLUMNS + 16) @(posedge clk);

		$display("run covered %0d requests: %0d put, %0d clear, %0d get, %0d read, %0d settings",
			n_items, n_put, n_clear, n_get, n_read, n_settings);
		$display("%0d results checked, %0d scrolls and %0d held backspaces seen",
			checked, scrolls, blocked_bs);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tmtw_pkg.sv
rtl/core/tmtw_stream_if.sv
rtl/core/tmtw_ram.sv
rtl/core/tmtw_ctrl.sv
rtl/core/tmtw_dp.sv
rtl/core/text_mode_terminal_writer.sv
rtl/core/tmtw_checker.sv
verif/tmtw_screen_checker.sv
verif/text_mode_terminal_writer_tb.sv
